// ----- hdl/gcsl_pkg.sv -----
// Shared constants, types and helper functions of the Gray-code structured light decoder.
package gcsl_pkg;

  // Pixel addressing and per-pixel store depth.
  localparam int PIX_W  = 20;
  localparam int PIXELS = 1 << PIX_W;

  // Field widths.
  localparam int FRAME_W  = 5;
  localparam int VAL_W    = 8;
  localparam int CODE_W   = 16;
  localparam int BITS_W   = 5;
  localparam int BITPOS_W = 4;

  // Number of code frames in each direction.
  localparam int HORZ_FRAMES = 10;
  localparam int VERT_FRAMES = 6;

  // Frame numbers with a fixed meaning.
  localparam logic [FRAME_W-1:0] FRAME_WHITE = 5'd0;
  localparam logic [FRAME_W-1:0] FRAME_BLACK = 5'd1;
  localparam logic [FRAME_W-1:0] FRAME_CODE0 = 5'd2;

  // Stream bus widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_USED_W  = PIX_W + 2 * CODE_W + VAL_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_HORZ_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_ENABLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HORZ_BITS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_BITS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHADE_THRESHOLD = 3'd4;

  localparam logic              RST_HORZ_ENABLE     = 1'b1;
  localparam logic              RST_VERT_ENABLE     = 1'b1;
  localparam logic [BITS_W-1:0] RST_HORZ_BITS       = 5'd10;
  localparam logic [BITS_W-1:0] RST_VERT_BITS       = 5'd6;
  localparam logic [VAL_W-1:0]  RST_SHADE_THRESHOLD = 8'd20;

  // Largest code width that the accumulators hold.
  localparam logic [BITS_W-1:0] BITS_MAX = 5'd16;

  // One per-pixel record of the store.
  typedef struct packed {
    logic [CODE_W-1:0] row_acc;
    logic [CODE_W-1:0] col_acc;
    logic [VAL_W-1:0]  black;
    logic [VAL_W-1:0]  white;
  } rec_t;

  // Decoded meaning of one accepted frame sample.
  typedef struct packed {
    logic                is_white;
    logic                is_black;
    logic                set_col;
    logic                set_row;
    logic [BITPOS_W-1:0] bitpos;
    logic                is_last;
  } dec_t;

  // Finished per-pixel result on its way to the output stage.
  typedef struct packed {
    logic [PIX_W-1:0]  pix;
    logic [CODE_W-1:0] col_gray;
    logic [CODE_W-1:0] row_gray;
    logic [VAL_W-1:0]  shade;
  } res_t;

  // Subtraction that clamps at zero.
  function automatic logic [VAL_W-1:0] sat_sub(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    sat_sub = (a > b) ? a - b : '0;
  endfunction

  // Gray to binary as a prefix XOR from the top bit down.
  function automatic logic [CODE_W-1:0] gray_to_bin(input logic [CODE_W-1:0] g);
    logic [CODE_W-1:0] b;
    b = g;
    b = b ^ (b >> 1);
    b = b ^ (b >> 2);
    b = b ^ (b >> 4);
    b = b ^ (b >> 8);
    gray_to_bin = b;
  endfunction

endpackage

// ----- hdl/gray_code_structured_light_decoder_top.sv -----
// Top level of the Gray-code structured light decoder: decode, store access and code update.
//
// The block takes one pixel sample per clock while in_tready is high and gives at most one result
// per sample. An accepted sample reads its pixel's record from the single per-pixel memory, is
// merged with any newer record still in flight, takes its white or black value on entering the
// second stage, where the Gray accumulator is updated and the record is written back, and on its
// last frame passes the result register to the output register. The one memory read at acceptance
// and one write in stage two set the rate of one sample per clock while in_tready is high, also
// for the same pixel in consecutive samples. After reset the accumulator memory is swept to zero,
// one entry per clock; in_tready stays low during the sweep while configuration writes are taken.
module gray_code_structured_light_decoder_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // frame_index [4:0], pixel_index [24:5], pixel_value [32:25], zero [39:33]
  input  logic [gcsl_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_pixel [19:0], col_code [35:20], row_code [51:36], shade_level [59:52],
  // fg_mask [60], zero [63:61]
  output logic [gcsl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [gcsl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gcsl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // Configuration registers.
  logic                          horz_en_r;
  logic                          vert_en_r;
  logic [gcsl_pkg::BITS_W-1:0]   horz_bits_r;
  logic [gcsl_pkg::BITS_W-1:0]   vert_bits_r;
  logic [gcsl_pkg::VAL_W-1:0]    thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horz_en_r   <= gcsl_pkg::RST_HORZ_ENABLE;
      vert_en_r   <= gcsl_pkg::RST_VERT_ENABLE;
      horz_bits_r <= gcsl_pkg::RST_HORZ_BITS;
      vert_bits_r <= gcsl_pkg::RST_VERT_BITS;
      thr_r       <= gcsl_pkg::RST_SHADE_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        gcsl_pkg::CFG_HORZ_ENABLE:     horz_en_r   <= cfg_wdata[0];
        gcsl_pkg::CFG_VERT_ENABLE:     vert_en_r   <= cfg_wdata[0];
        gcsl_pkg::CFG_HORZ_BITS:       horz_bits_r <= cfg_wdata[gcsl_pkg::BITS_W-1:0];
        gcsl_pkg::CFG_VERT_BITS:       vert_bits_r <= cfg_wdata[gcsl_pkg::BITS_W-1:0];
        gcsl_pkg::CFG_SHADE_THRESHOLD: thr_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [gcsl_pkg::FRAME_W-1:0] in_frame;
  logic [gcsl_pkg::PIX_W-1:0]   in_pix;
  logic [gcsl_pkg::VAL_W-1:0]   in_val;

  assign in_frame = in_tdata[gcsl_pkg::FRAME_W-1:0];
  assign in_pix   = in_tdata[gcsl_pkg::FRAME_W +: gcsl_pkg::PIX_W];
  assign in_val   = in_tdata[gcsl_pkg::FRAME_W + gcsl_pkg::PIX_W +: gcsl_pkg::VAL_W];

  // Frame decode. Pixel indexes always fall inside the store, so only the frame
  // number can make a sample void.
  logic [gcsl_pkg::FRAME_W-1:0] n_horz;
  logic [gcsl_pkg::FRAME_W-1:0] n_vert;
  logic [gcsl_pkg::FRAME_W-1:0] last_frame;
  logic [gcsl_pkg::FRAME_W-1:0] code_k;
  logic [gcsl_pkg::FRAME_W-1:0] code_pos;
  logic [gcsl_pkg::BITS_W-1:0]  bits_sel;
  logic [gcsl_pkg::BITS_W-1:0]  bits_lim;
  logic [gcsl_pkg::BITS_W-1:0]  bitpos_full;
  logic                         is_code;
  logic                         is_col;
  logic                         take_bit;
  logic                         in_void;
  gcsl_pkg::dec_t               in_dec;

  always_comb begin
    n_horz      = horz_en_r ? gcsl_pkg::FRAME_W'(gcsl_pkg::HORZ_FRAMES) : '0;
    n_vert      = vert_en_r ? gcsl_pkg::FRAME_W'(gcsl_pkg::VERT_FRAMES) : '0;
    last_frame  = gcsl_pkg::FRAME_BLACK + n_horz + n_vert;
    in_void     = in_frame > last_frame;
    is_code     = in_frame >= gcsl_pkg::FRAME_CODE0;
    code_k      = in_frame - gcsl_pkg::FRAME_CODE0;
    is_col      = is_code && (code_k < n_horz);
    code_pos    = is_col ? code_k : code_k - n_horz;
    bits_sel    = is_col ? horz_bits_r : vert_bits_r;
    bits_lim    = (bits_sel > gcsl_pkg::BITS_MAX) ? gcsl_pkg::BITS_MAX : bits_sel;
    take_bit    = is_code && (code_pos < bits_lim);
    bitpos_full = bits_lim - code_pos - 1'b1;

    in_dec.is_white = in_frame == gcsl_pkg::FRAME_WHITE;
    in_dec.is_black = in_frame == gcsl_pkg::FRAME_BLACK;
    in_dec.set_col  = take_bit && is_col;
    in_dec.set_row  = take_bit && !is_col;
    in_dec.bitpos   = bitpos_full[gcsl_pkg::BITPOS_W-1:0];
    in_dec.is_last  = in_frame == last_frame;
  end

  // Pipeline control.
  logic clr_busy;
  logic res_ready;
  logic s1_vld_r;
  logic s1_vld_nxt;
  logic s2_vld_r;
  logic s2_vld_nxt;
  logic s1_ld;
  logic s1_go;
  logic s2_go;
  logic s1_free;
  logic s2_free;

  gcsl_pkg::dec_t             s1_dec_r;
  logic [gcsl_pkg::PIX_W-1:0] s1_pix_r;
  logic [gcsl_pkg::VAL_W-1:0] s1_val_r;

  gcsl_pkg::dec_t             s2_dec_r;
  logic [gcsl_pkg::PIX_W-1:0] s2_pix_r;
  logic [gcsl_pkg::VAL_W-1:0] s2_val_r;
  gcsl_pkg::rec_t             s2_rec_r;
  logic [gcsl_pkg::VAL_W-1:0] s2_shade_r;

  // A sample that gives no result leaves stage two without waiting on the output side.
  always_comb begin
    s2_go     = s2_vld_r && (!s2_dec_r.is_last || res_ready);
    s2_free   = !s2_vld_r || s2_go;
    s1_go     = s1_vld_r && s2_free;
    s1_free   = !s1_vld_r || s2_free;
    in_tready = !clr_busy && s1_free;
    s1_ld     = in_tvalid && in_tready;
  end

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (s1_ld) begin
      s1_vld_nxt = !in_void;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
    s2_vld_nxt = s2_vld_r;
    if (s1_go) begin
      s2_vld_nxt = 1'b1;
    end else if (s2_go) begin
      s2_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  // Stage 1 captures the sample while the store reads its record.
  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_dec_r <= in_dec;
      s1_pix_r <= in_pix;
      s1_val_r <= in_val;
    end
  end

  // Per-pixel record store.
  gcsl_pkg::rec_t rd_rec;
  gcsl_pkg::rec_t s2_wr_rec;

  gcsl_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (s1_ld),
    .rd_addr  (in_pix),
    .rd_data  (rd_rec),
    .wr_en    (s2_go),
    .wr_addr  (s2_pix_r),
    .wr_data  (s2_wr_rec),
    .clr_busy (clr_busy)
  );

  // Copy of the newest record written, for a read that raced with that write.
  logic                       lw_vld_r;
  logic [gcsl_pkg::PIX_W-1:0] lw_pix_r;
  gcsl_pkg::rec_t             lw_rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_vld_r <= 1'b0;
    end else if (s2_go) begin
      lw_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      lw_pix_r <= s2_pix_r;
      lw_rec_r <= s2_wr_rec;
    end
  end

  // Stage 1 to 2: pick the newest record, apply white (clearing both codes) or black, form the shading.
  gcsl_pkg::rec_t             base_rec;
  gcsl_pkg::rec_t             mrg_rec;
  logic [gcsl_pkg::VAL_W-1:0] mrg_shade;

  always_comb begin
    if (s2_vld_r && (s2_pix_r == s1_pix_r)) begin
      base_rec = s2_wr_rec;
    end else if (lw_vld_r && (lw_pix_r == s1_pix_r)) begin
      base_rec = lw_rec_r;
    end else begin
      base_rec = rd_rec;
    end
    mrg_rec = base_rec;
    if (s1_dec_r.is_white) begin
      mrg_rec.white   = s1_val_r;
      mrg_rec.col_acc = '0;
      mrg_rec.row_acc = '0;
    end
    if (s1_dec_r.is_black) begin
      mrg_rec.black = s1_val_r;
    end
    mrg_shade = gcsl_pkg::sat_sub(mrg_rec.white, mrg_rec.black);
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_dec_r   <= s1_dec_r;
      s2_pix_r   <= s1_pix_r;
      s2_val_r   <= s1_val_r;
      s2_rec_r   <= mrg_rec;
      s2_shade_r <= mrg_shade;
    end
  end

  // Stage 2: decide the code bit and set it in the accumulator of its direction.
  logic                        code_bit;
  logic [gcsl_pkg::CODE_W-1:0] bit_mask;

  always_comb begin
    code_bit  = gcsl_pkg::sat_sub(s2_shade_r, s2_val_r)
              < gcsl_pkg::sat_sub(s2_val_r, s2_rec_r.black);
    bit_mask  = gcsl_pkg::CODE_W'(1) << s2_dec_r.bitpos;
    s2_wr_rec = s2_rec_r;
    if (code_bit && s2_dec_r.set_col) begin
      s2_wr_rec.col_acc = s2_rec_r.col_acc | bit_mask;
    end
    if (code_bit && s2_dec_r.set_row) begin
      s2_wr_rec.row_acc = s2_rec_r.row_acc | bit_mask;
    end
  end

  // Result of the pixel's last frame.
  logic           res_valid;
  gcsl_pkg::res_t res;

  always_comb begin
    res_valid    = s2_vld_r && s2_dec_r.is_last;
    res.pix      = s2_pix_r;
    res.col_gray = s2_wr_rec.col_acc;
    res.row_gray = s2_wr_rec.row_acc;
    res.shade    = s2_shade_r;
  end

  gcsl_output u_output (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res             (res),
    .res_ready       (res_ready),
    .horz_enable     (horz_en_r),
    .vert_enable     (vert_en_r),
    .shade_threshold (thr_r),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata)
  );

endmodule

// ----- hdl/gcsl_store.sv -----
// Per-pixel record memory with registered read and a clearing sweep after reset.
module gcsl_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [gcsl_pkg::PIX_W-1:0] rd_addr,
  output gcsl_pkg::rec_t             rd_data,
  input  logic                       wr_en,
  input  logic [gcsl_pkg::PIX_W-1:0] wr_addr,
  input  gcsl_pkg::rec_t             wr_data,
  output logic                       clr_busy
);

  gcsl_pkg::rec_t mem_r [gcsl_pkg::PIXELS];
  gcsl_pkg::rec_t rd_data_r;

  logic                       clr_busy_r;
  logic                       clr_busy_nxt;
  logic [gcsl_pkg::PIX_W-1:0] clr_cnt_r;
  logic [gcsl_pkg::PIX_W-1:0] clr_cnt_nxt;

  logic                       mem_we;
  logic [gcsl_pkg::PIX_W-1:0] mem_wa;
  gcsl_pkg::rec_t             mem_wd;

  // The sweep walks every entry once and then hands the port to the pipeline.
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (&clr_cnt_r) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  // Write port shared between the sweep and the pipeline.
  always_comb begin
    mem_we = clr_busy_r | wr_en;
    mem_wa = clr_busy_r ? clr_cnt_r : wr_addr;
    mem_wd = clr_busy_r ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

// ----- hdl/gcsl_output.sv -----
// Result stages: Gray to binary conversion, mask compare and the output register.
module gcsl_output (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           res_valid,
  input  gcsl_pkg::res_t                 res,
  output logic                           res_ready,
  input  logic                           horz_enable,
  input  logic                           vert_enable,
  input  logic [gcsl_pkg::VAL_W-1:0]     shade_threshold,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [gcsl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic           s3_vld_r;
  logic           s3_vld_nxt;
  gcsl_pkg::res_t s3_res_r;

  logic                             out_vld_r;
  logic                             out_vld_nxt;
  logic [gcsl_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [gcsl_pkg::OUT_TDATA_W-1:0] out_data_nxt;

  logic                         s4_free;
  logic                         s3_go;
  logic                         s3_ld;
  logic [gcsl_pkg::CODE_W-1:0]  col_bin;
  logic [gcsl_pkg::CODE_W-1:0]  row_bin;
  logic                         fg_mask;

  // Handshake between the result register and the output register.
  always_comb begin
    s4_free   = !out_vld_r || out_tready;
    s3_go     = s3_vld_r && s4_free;
    res_ready = !s3_vld_r || s4_free;
    s3_ld     = res_valid && res_ready;
  end

  always_comb begin
    s3_vld_nxt = s3_vld_r;
    if (s3_ld) begin
      s3_vld_nxt = 1'b1;
    end else if (s3_go) begin
      s3_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s3_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ld) begin
      s3_res_r <= res;
    end
  end

  // Code conversion and foreground decision.
  always_comb begin
    col_bin = horz_enable ? gcsl_pkg::gray_to_bin(s3_res_r.col_gray) : '0;
    row_bin = vert_enable ? gcsl_pkg::gray_to_bin(s3_res_r.row_gray) : '0;
    fg_mask = s3_res_r.shade > shade_threshold;
    out_data_nxt = {
      {(gcsl_pkg::OUT_TDATA_W - gcsl_pkg::OUT_USED_W){1'b0}},
      fg_mask, s3_res_r.shade, row_bin, col_bin, s3_res_r.pix
    };
  end

  // Output register: takes a new result whenever it is empty or the current one is taken.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s3_go) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
